// File: rtl/core/inverse_hessian_step_clamp_macros.svh
// Assertion macros shared by the quasi-Newton step block.
`ifndef INVERSE_HESSIAN_STEP_CLAMP_MACROS_SVH
`define INVERSE_HESSIAN_STEP_CLAMP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define IHSC_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define IHSC_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ihsc_pkg.sv
// Package: shared widths, codes and control structs of the step block.
package ihsc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int ACC_BITS   = 64;
  localparam int FRAC_BITS  = 24;
  localparam int LIMIT_BITS = 31;
  localparam int CMD_BITS   = 2;
  localparam int POS_BITS   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ACTIVE_W   = 5;

  // Transaction commands
  localparam logic [CMD_BITS-1:0] CMD_MATRIX   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_GRADIENT = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_COMPUTE  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PAIRS = 2'd1;

  localparam logic [LIMIT_BITS-1:0] STEP_LIMIT_RESET   = 31'd8388608;
  localparam logic [ACTIVE_W-1:0]   ACTIVE_PAIRS_RESET = 5'd16;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } ihsc_mac_ctl_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] num;
    logic [LIMIT_BITS-1:0] scale;
    logic [VALUE_BITS-1:0] den;
  } ihsc_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ihsc_div_sts_t;

endpackage

// File: rtl/core/ihsc_if.sv
// Channel interfaces: command input, step results and configuration writes.
interface ihsc_in_if;
  import ihsc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [CMD_BITS-1:0]          cmd;
  logic [POS_BITS-1:0]          row;
  logic [POS_BITS-1:0]          col;
  logic signed [VALUE_BITS-1:0] value;
  modport source (output valid, cmd, row, col, value, input ready);
  modport sink (input valid, cmd, row, col, value, output ready);
endinterface

interface ihsc_out_if;
  import ihsc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [POS_BITS-1:0]          element_index;
  logic signed [VALUE_BITS-1:0] step_value;
  logic                         was_scaled;
  logic                         last;
  modport source (output valid, element_index, step_value, was_scaled, last, input ready);
  modport sink (input valid, element_index, step_value, was_scaled, last, output ready);
endinterface

interface ihsc_cfg_if;
  import ihsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/ihsc_mac.sv
// Multiply-accumulate unit with saturation and Q-format rounding of the row sum.
module ihsc_mac (
  input  logic                                  clk,
  input  ihsc_pkg::ihsc_mac_ctl_t               ctl,
  input  logic signed [ihsc_pkg::VALUE_BITS-1:0] m_in,
  input  logic signed [ihsc_pkg::VALUE_BITS-1:0] g_in,
  output logic signed [ihsc_pkg::VALUE_BITS-1:0] step_out
);
  import ihsc_pkg::*;

  localparam int SH_W = ACC_BITS - FRAC_BITS;
  localparam logic [SH_W-1:0] NEG_LIM = SH_W'(64'd1 << (VALUE_BITS - 1));
  localparam logic [SH_W-1:0] POS_LIM = SH_W'((64'd1 << (VALUE_BITS - 1)) - 64'd1);

  logic signed [ACC_BITS-1:0] prod_r;
  logic signed [ACC_BITS-1:0] acc_r;
  logic signed [ACC_BITS-1:0] acc_nxt;
  logic signed [ACC_BITS:0]   sum;
  logic [ACC_BITS-1:0]        acc_mag;
  logic [SH_W-1:0]            sh;

  // Saturating add of the registered product
  always_comb begin
    sum = {acc_r[ACC_BITS-1], acc_r} + {prod_r[ACC_BITS-1], prod_r};
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      acc_nxt = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      acc_nxt = sum[ACC_BITS-1:0];
    end
  end

  // Hold the product and the running sum
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= m_in * g_in;
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  // Negate, drop fraction bits toward zero, saturate
  always_comb begin
    acc_mag = acc_r[ACC_BITS-1] ? (~acc_r + 1'b1) : acc_r;
    sh      = acc_mag[ACC_BITS-1:FRAC_BITS];
    if (!acc_r[ACC_BITS-1]) begin
      step_out = (sh > NEG_LIM) ? -VALUE_BITS'(NEG_LIM) : -VALUE_BITS'(sh);
    end else begin
      step_out = (sh > POS_LIM) ? VALUE_BITS'(POS_LIM) : VALUE_BITS'(sh);
    end
  end

endmodule

// File: rtl/core/ihsc_muldiv.sv
// Serial unit giving floor(num * scale / den), two radix steps per scale bit.
module ihsc_muldiv (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ihsc_pkg::ihsc_div_req_t              req,
  output ihsc_pkg::ihsc_div_sts_t              sts,
  output logic [ihsc_pkg::LIMIT_BITS-1:0]      quo
);
  import ihsc_pkg::*;

  localparam int CNT_W = $clog2(LIMIT_BITS);

  logic [VALUE_BITS-1:0] num_r, den_r, rem_r, rem_nxt, r1;
  logic [LIMIT_BITS-1:0] scale_r, q_r, q_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r, done_r, b1, b2;

  // One scale bit: double the remainder, then add num when the bit is set
  always_comb begin
    if (rem_r >= den_r - rem_r) begin
      r1 = rem_r - (den_r - rem_r);
      b1 = 1'b1;
    end else begin
      r1 = rem_r + rem_r;
      b1 = 1'b0;
    end
    b2      = 1'b0;
    rem_nxt = r1;
    if (scale_r[cnt_r]) begin
      if (r1 >= den_r - num_r) begin
        rem_nxt = r1 - (den_r - num_r);
        b2      = 1'b1;
      end else begin
        rem_nxt = r1 + num_r;
      end
    end
    q_nxt = (q_r << 1) + LIMIT_BITS'(b1) + LIMIT_BITS'(b2);
  end

  // Control: run from the top scale bit down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r   <= req.num;
      den_r   <= req.den;
      scale_r <= req.scale;
      rem_r   <= '0;
      q_r     <= '0;
      cnt_r   <= CNT_W'(LIMIT_BITS - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = q_r;

endmodule

// File: rtl/core/inverse_hessian_step_clamp.sv
// Top level: loads, quasi-Newton step sequencer, scaling and result register.
// Loads are taken in S_IDLE. A compute forms the step via the shared MAC (each
// multiply-accumulate in S_RD, S_MUL, S_ACC; each row closed in S_FIN), then
// sends each element via S_SRD, S_SLD, S_SDIV (serial scaler, if scaled), S_OUT.
// Results leave one per element as the sink takes them; no input meanwhile.
// Synchronous active-low reset clears control state and restores the registers.
module inverse_hessian_step_clamp #(
  parameter int MAX_PAIRS = 16
) (
  input  logic clk,
  input  logic rst_n,
  ihsc_in_if.sink    in_ch,
  ihsc_out_if.source out_ch,
  ihsc_cfg_if.sink   cfg_ch
);
  import ihsc_pkg::*;
  `include "inverse_hessian_step_clamp_macros.svh"

  localparam int IDX_W     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int MAT_DEPTH = 1 << (2 * IDX_W);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_ACC  = 9'b000001000,
    S_FIN  = 9'b000010000,
    S_SRD  = 9'b000100000,
    S_SLD  = 9'b001000000,
    S_SDIV = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [LIMIT_BITS-1:0] limit_r;
  logic [ACTIVE_W-1:0]   active_r;
  logic [IDX_W-1:0]      i_r, i_nxt, j_r, j_nxt, n_last_r, n_last_nxt;
  logic [VALUE_BITS-1:0] largest_r, largest_nxt, step_mag, sld_mag;

  logic signed [VALUE_BITS-1:0] mat_mem [MAT_DEPTH];
  logic signed [VALUE_BITS-1:0] grad_mem [MAX_PAIRS];
  logic signed [VALUE_BITS-1:0] step_mem [MAX_PAIRS];
  logic signed [VALUE_BITS-1:0] mat_q_r, grad_q_r, step_q_r, fin_step;

  logic [POS_BITS-1:0]          oidx_r, oidx_nxt;
  logic signed [VALUE_BITS-1:0] oval_r, oval_nxt;
  logic                         oscl_r, oscl_nxt, olast_r, olast_nxt;

  logic          in_fire, scaled;
  ihsc_mac_ctl_t mac_ctl;
  ihsc_div_req_t div_req;
  ihsc_div_sts_t div_sts;
  logic [LIMIT_BITS-1:0] div_q;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign scaled       = largest_r > {1'b0, limit_r};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= STEP_LIMIT_RESET;
      active_r <= ACTIVE_PAIRS_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_STEP_LIMIT:   limit_r  <= cfg_ch.data[LIMIT_BITS-1:0];
        REG_ACTIVE_PAIRS: active_r <= cfg_ch.data[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stores: write on load or row finish, read registered every cycle
  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.cmd == CMD_MATRIX) && (int'(in_ch.row) < MAX_PAIRS)
        && (int'(in_ch.col) < MAX_PAIRS)) begin
      mat_mem[{IDX_W'(in_ch.row), IDX_W'(in_ch.col)}] <= in_ch.value;
    end
    if (in_fire && (in_ch.cmd == CMD_GRADIENT) && (int'(in_ch.row) < MAX_PAIRS)) begin
      grad_mem[IDX_W'(in_ch.row)] <= in_ch.value;
    end
    if (state_r == S_FIN) begin
      step_mem[i_r] <= fin_step;
    end
    mat_q_r  <= mat_mem[{i_r, j_r}];
    grad_q_r <= grad_mem[j_r];
    step_q_r <= step_mem[i_r];
  end

  ihsc_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .m_in     (mat_q_r),
    .g_in     (grad_q_r),
    .step_out (fin_step)
  );

  ihsc_muldiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts),
    .quo   (div_q)
  );

  assign step_mag = fin_step[VALUE_BITS-1] ? (~fin_step + 1'b1) : fin_step;
  assign sld_mag  = step_q_r[VALUE_BITS-1] ? (~step_q_r + 1'b1) : step_q_r;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    n_last_nxt  = n_last_r;
    largest_nxt = largest_r;
    oidx_nxt    = oidx_r;
    oval_nxt    = oval_r;
    oscl_nxt    = oscl_r;
    olast_nxt   = olast_r;
    mac_ctl     = '0;
    div_req     = '{start: 1'b0, num: sld_mag, scale: limit_r, den: largest_r};
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.cmd == CMD_COMPUTE)) begin
          if (active_r == '0) begin
            n_last_nxt = '0;
          end else if (int'(active_r) > MAX_PAIRS) begin
            n_last_nxt = IDX_W'(MAX_PAIRS - 1);
          end else begin
            n_last_nxt = IDX_W'(active_r - 1'b1);
          end
          i_nxt         = '0;
          j_nxt         = '0;
          largest_nxt   = '0;
          mac_ctl.clear = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_RD: state_nxt = S_MUL;
      S_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_nxt      = S_ACC;
      end
      S_ACC: begin
        mac_ctl.acc_en = 1'b1;
        if (j_r == n_last_r) begin
          state_nxt = S_FIN;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        if (step_mag > largest_r) begin
          largest_nxt = step_mag;
        end
        mac_ctl.clear = 1'b1;
        j_nxt         = '0;
        if (i_r == n_last_r) begin
          i_nxt     = '0;
          state_nxt = S_SRD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_SRD: state_nxt = S_SLD;
      S_SLD: begin
        oidx_nxt  = POS_BITS'(i_r);
        oscl_nxt  = scaled;
        olast_nxt = (i_r == n_last_r);
        if (scaled) begin
          div_req.start = 1'b1;
          state_nxt     = S_SDIV;
        end else begin
          oval_nxt  = step_q_r;
          state_nxt = S_OUT;
        end
      end
      S_SDIV: begin
        if (div_sts.done) begin
          oval_nxt  = step_q_r[VALUE_BITS-1] ? -VALUE_BITS'(div_q) : VALUE_BITS'(div_q);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (olast_r) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_SRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      largest_r <= '0;
    end else begin
      state_r   <= state_nxt;
      largest_r <= largest_nxt;
    end
  end

  // Hold counters and the result register
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    n_last_r <= n_last_nxt;
    oidx_r   <= oidx_nxt;
    oval_r   <= oval_nxt;
    oscl_r   <= oscl_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid         = (state_r == S_OUT);
  assign out_ch.element_index = oidx_r;
  assign out_ch.step_value    = oval_r;
  assign out_ch.was_scaled    = oscl_r;
  assign out_ch.last          = olast_r;

  // Checks
  `IHSC_CHECK(a_no_overlap, !(in_ch.ready && out_ch.valid), "input taken while result pending")
  `IHSC_CHECK(a_div_in_state, !div_sts.busy || (state_r == S_SDIV), "scaler busy outside wait")
  `IHSC_NEXT(a_last_idle, out_ch.valid && out_ch.ready && out_ch.last, state_r == S_IDLE, "run did not end on last")
  `IHSC_CHECK(a_scaled_flag, !(out_ch.valid && out_ch.was_scaled) || scaled, "scaled flag without excess")
  `IHSC_NEXT(a_row_clear, state_r == S_FIN, (state_r == S_RD) || (state_r == S_SRD), "row finish went astray")

endmodule

// File: verif/ihsc_tb_if.sv
// Testbench package: type of one expected step element.
package ihsc_tb_pkg;
  import ihsc_pkg::*;

  // One expected step element
  typedef struct packed {
    logic [POS_BITS-1:0]          element_index;
    logic signed [VALUE_BITS-1:0] step_value;
    logic                         was_scaled;
    logic                         last;
  } step_elem_t;
endpackage

// File: verif/inverse_hessian_step_clamp_tb.sv
// Testbench: checks the clamped quasi-Newton step block against a behavioural predictor.
module inverse_hessian_step_clamp_tb;
  import ihsc_pkg::*;
  import ihsc_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count = 0;

  ihsc_in_if  in_ch ();
  ihsc_out_if out_ch ();
  ihsc_cfg_if cfg_ch ();

  inverse_hessian_step_clamp i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow state of the block
  logic signed [VALUE_BITS-1:0] mat_shadow [16][16];
  logic signed [VALUE_BITS-1:0] grad_shadow [16];
  logic [LIMIT_BITS-1:0]        limit_shadow;
  logic [ACTIVE_W-1:0]          pairs_shadow;
  step_elem_t                   step_queue [$];

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) return 64'sh7FFFFFFFFFFFFFFF;
    if (a < 0 && b < 0 && s >= 0) return 64'sh8000000000000000;
    return s;
  endfunction

  // Form the step, clamp it and queue the expected elements
  function automatic void predict_step();
    int n;
    longint acc;
    longint prod;
    logic [63:0] m;
    logic signed [VALUE_BITS-1:0] stp [16];
    logic [VALUE_BITS:0] mg;
    logic [VALUE_BITS:0] largest;
    logic [95:0] scaled_mag;
    bit scaled;
    step_elem_t e;
    n = pairs_shadow;
    if (n < 1) n = 1;
    if (n > 16) n = 16;
    largest = '0;
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < n; j++) begin
        prod = longint'(mat_shadow[i][j]) * longint'(grad_shadow[j]);
        acc = sat_sum(acc, prod);
      end
      m = (acc < 0) ? 64'(-acc) : 64'(acc);
      m = m >> FRAC_BITS;
      if (acc > 0) begin
        stp[i] = (m > 64'h80000000) ? 32'sh80000000 : -32'(m);
      end else begin
        stp[i] = (m > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(m);
      end
      mg = stp[i][VALUE_BITS-1] ? 33'(-{stp[i][31], stp[i]}) : 33'(stp[i]);
      if (mg > largest) largest = mg;
    end
    scaled = largest > limit_shadow;
    for (int i = 0; i < n; i++) begin
      if (scaled) begin
        mg = stp[i][VALUE_BITS-1] ? 33'(-{stp[i][31], stp[i]}) : 33'(stp[i]);
        scaled_mag = (96'(mg) * 96'(limit_shadow)) / 96'(largest);
        stp[i] = stp[i][VALUE_BITS-1] ? -32'(scaled_mag) : 32'(scaled_mag);
      end
      e.element_index = i[3:0];
      e.step_value = stp[i];
      e.was_scaled = scaled;
      e.last = (i == n - 1);
      step_queue.push_back(e);
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  // Send one transaction after a random gap; valid stays up until the next gap
  task automatic send_item(logic [CMD_BITS-1:0] c, int r, int cl, logic [31:0] v);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= c;
    in_ch.row   <= r[3:0];
    in_ch.col   <= cl[3:0];
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    if (c == CMD_MATRIX) mat_shadow[r][cl] = v;
    else if (c == CMD_GRADIENT) grad_shadow[r] = v;
    else if (c == CMD_COMPUTE) predict_step();
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_STEP_LIMIT) limit_shadow = d[LIMIT_BITS-1:0];
    else pairs_shadow = d[ACTIVE_W-1:0];
    @(posedge clk);
  endtask

  // Drop valid and hold until every expected element has left the block
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (step_queue.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 32'h02000000) - 32'h01000000;
      default: return $urandom_range(0, 32'h00200000) - 32'h00100000;
    endcase
  endfunction

  // Load all entries in use, then compute
  task automatic load_and_compute(int n, int mode);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) send_item(CMD_MATRIX, i, j, rand_value(mode));
      send_item(CMD_GRADIENT, i, 0, rand_value(mode));
    end
    send_item(CMD_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
  endtask

  // Extremes of values, unknown command and register defaults
  task automatic test_directed();
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 16; j++) mat_shadow[i][j] = 0;
      grad_shadow[i] = 0;
    end
    write_reg(REG_ACTIVE_PAIRS, 32'd2);
    send_item(CMD_MATRIX, 0, 0, 32'h80000000);
    send_item(CMD_MATRIX, 0, 1, 32'h80000000);
    send_item(CMD_MATRIX, 1, 0, 32'h7FFFFFFF);
    send_item(CMD_MATRIX, 1, 1, 32'h00000000);
    send_item(CMD_GRADIENT, 0, 15, 32'h80000000);
    send_item(CMD_GRADIENT, 1, 0, 32'h80000000);
    send_item(2'd3, 15, 15, 32'hFFFFFFFF);
    send_item(CMD_COMPUTE, 0, 0, 32'h0);
    send_item(CMD_GRADIENT, 0, 0, 32'h01000000);
    send_item(CMD_GRADIENT, 1, 0, 32'hFF000000);
    send_item(CMD_MATRIX, 1, 1, 32'h01000000);
    send_item(CMD_COMPUTE, 0, 0, 32'h0);
    drain();
    write_reg(REG_STEP_LIMIT, 32'h7FFFFFFF);
    send_item(CMD_COMPUTE, 15, 15, 32'hFFFFFFFF);
    drain();
    write_reg(REG_STEP_LIMIT, 32'h0);
    send_item(CMD_COMPUTE, 0, 0, 32'h0);
    drain();
    write_reg(REG_ACTIVE_PAIRS, 32'd0);
    send_item(CMD_COMPUTE, 0, 0, 32'h0);
    drain();
  endtask

  // Random loads and computes over several register settings
  task automatic test_random();
    int n;
    for (int k = 0; k < 10; k++) begin
      case (k % 4)
        0: write_reg(REG_STEP_LIMIT, $urandom);
        1: write_reg(REG_STEP_LIMIT, $urandom_range(0, 32'h02000000));
        2: write_reg(REG_STEP_LIMIT, 32'h7FFFFFFF);
        default: write_reg(REG_STEP_LIMIT, 32'd0);
      endcase
      n = (k == 5) ? 16 : $urandom_range(1, 5);
      // Over-range count acts as the full size; all rows were loaded when k was 5
      write_reg(REG_ACTIVE_PAIRS, (k == 7) ? 32'h1F : n);
      load_and_compute(n, k % 3);
      // Rewrite a few entries, including ignored commands, and compute again
      for (int t = 0; t < 6; t++) begin
        if ($urandom_range(0, 5) == 0) send_item(2'd3, $urandom, $urandom, $urandom);
        else if (t % 2) send_item(CMD_GRADIENT, $urandom_range(0, n - 1), $urandom,
                                  rand_value(k % 3));
        else send_item(CMD_MATRIX, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                       rand_value(k % 3));
      end
      send_item(CMD_COMPUTE, 0, 0, $urandom);
      drain();
    end
  endtask

  // Check each result against the oldest expectation, with a random wait per transaction
  initial begin
    int stall;
    step_elem_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      if (step_queue.size() == 0) begin
        report_mismatch("unexpected element", out_ch.element_index, -1);
      end else begin
        want = step_queue.pop_front();
        if (out_ch.element_index !== want.element_index)
          report_mismatch("element_index", out_ch.element_index, want.element_index);
        if (out_ch.step_value !== want.step_value)
          report_mismatch("step_value", out_ch.step_value, want.step_value);
        if (out_ch.was_scaled !== want.was_scaled)
          report_mismatch("was_scaled", out_ch.was_scaled, want.was_scaled);
        if (out_ch.last !== want.last)
          report_mismatch("last", out_ch.last, want.last);
      end
    end
  end

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_MATRIX;
    in_ch.row    <= '0;
    in_ch.col    <= '0;
    in_ch.value  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_STEP_LIMIT;
    cfg_ch.data  <= '0;
    limit_shadow = STEP_LIMIT_RESET;
    pairs_shadow = ACTIVE_PAIRS_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && step_queue.size() == 0) begin
      $display("** inverse_hessian_step_clamp: PASSED **");
    end else begin
      $display("** inverse_hessian_step_clamp: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #40000000;
    $display("** inverse_hessian_step_clamp: FAILED **");
    $finish;
  end
endmodule
